// ===== hdl/qncp_pkg.sv =====
// Shared types, constants and helpers of the near-plane clip and projection block.
`timescale 1ns / 1ps
package qncp_pkg;

    localparam int NEAR_PLANE_DEF   = 8;
    localparam int FOCAL_LENGTH_DEF = 160;
    localparam int FOCAL_MAX        = 1024;
    localparam int PAD_Q16          = 36045;
    localparam int CENTRE_X_Q16     = 200 * 65536;
    localparam int BANK_MIN         = 33;

    // camera-space widths
    localparam int DX_W  = 34;          // world delta
    localparam int PR_W  = DX_W + 16;   // delta times Q1.14
    localparam int LXZ_W = 38;          // camera-space lateral / depth
    localparam int DL_W  = LXZ_W + 1;   // edge delta
    localparam int T_W   = 17;          // clip parameter, Q1.16 up to one
    localparam int OX_W  = 41;          // clipped lateral value
    localparam int LY_W  = 44;          // height / depth after pitch
    localparam int QP_W  = 33;          // projection quotient bits

    typedef enum logic [2:0] {
        CFG_CAM_X      = 3'd0,
        CFG_CAM_Z      = 3'd1,
        CFG_CAM_HEIGHT = 3'd2,
        CFG_YAW        = 3'd3,
        CFG_PITCH      = 3'd4,
        CFG_BANK       = 3'd5,
        CFG_HORIZON    = 3'd6,
        CFG_VIEW_MODE  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_z;
        logic signed [31:0] cam_height;
        logic signed [15:0] yaw_s;
        logic signed [15:0] yaw_c;
        logic signed [15:0] pitch_s;
        logic signed [15:0] pitch_c;
        logic signed [15:0] bank_s;
        logic signed [15:0] bank_c;
        logic signed [31:0] horizon;
        logic               pilot;
    } cfg_t;

    typedef struct packed {
        logic [3:0][LXZ_W-1:0] lx;
        logic [3:0][LXZ_W-1:0] lz;
    } tile_t;

    typedef struct packed {
        logic [2:0] idx;
        logic [2:0] cnt;
        logic       vis;
        logic       last;
    } meta_t;

    typedef struct packed {
        logic signed [LXZ_W-1:0] lx_i;
        logic signed [LXZ_W-1:0] lz_i;
        logic signed [LXZ_W-1:0] lx_j;
        logic signed [LXZ_W-1:0] lz_j;
        logic                    crossing;
        meta_t                   meta;
    } vtx_tok_t;

    typedef struct packed {
        logic signed [LXZ_W-1:0] lx_i;
        logic signed [DL_W-1:0]  dlx;
        logic signed [LXZ_W-1:0] lz_i;
        logic                    crossing;
        logic                    pos;
        logic                    den_zero;
        meta_t                   meta;
    } tdiv_tag_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -48'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hdl/quad_near_clip_project.sv =====
// Top level: configuration registers, stream ports and the clip/projection pipeline.
`timescale 1ns / 1ps
// Usage
//   Slave stream s_*: one word per ground tile. s_tdata, from bit 0 up: tile_x[31:0],
//   tile_z[31:0], cell_size[23:0], eye_offset[31:0].
//   Master stream m_*: one word per screen vertex of the clipped tile polygon, in
//   polygon order; m_tlast marks the final vertex of a tile. m_tuser is the visible
//   flag: a tile that keeps fewer than three vertices leaves as a single word with
//   m_tuser low, all data zero and m_tlast high.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr at the clock edge
//   (cam_x, cam_z, cam_height, yaw, pitch, bank, horizon_row, view_mode). Write
//   only while no tile is in flight.
//   Path: a tile runs through the front end, the sequencer and the vertex stages,
//   which hold two pipelined dividers (17 and 33 quotient bits, one bit per stage).
//   Throughput: a tile holds the vertex sequencer until it has emitted its vertices
//   (3 to 6), or its single word when culled; tiles behind it queue in the front
//   stages, and new tiles enter every cycle while the sequencer has room and m_* moves.
//   Reset: asynchronous, active low; empties every stage and loads the register
//   defaults (identity sin/cos pairs, everything else zero).
//   Stall: when m_tready is low with a word on m_*, the whole pipeline holds, the
//   output word stays on m_*, and s_tready drops until the output moves again.
module quad_near_clip_project import qncp_pkg::*; #(
    parameter int NEAR_PLANE   = NEAR_PLANE_DEF,
    parameter int FOCAL_LENGTH = FOCAL_LENGTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // tile_x, tile_z, cell_size, eye_offset
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // screen_x, screen_y, vertex_index, vertex_count, 2'b0
    output logic         m_tuser,   // visible
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    // configuration registers
    logic signed [31:0] cam_x_reg, cam_z_reg, cam_height_reg, horizon_reg;
    logic        [31:0] yaw_reg, pitch_reg, bank_reg;
    logic               view_mode_reg;
    cfg_t               cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg      <= '0;
            cam_z_reg      <= '0;
            cam_height_reg <= '0;
            yaw_reg        <= 32'd16384;
            pitch_reg      <= 32'd16384;
            bank_reg       <= 32'd16384;
            horizon_reg    <= '0;
            view_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_CAM_X:      cam_x_reg      <= cfg_wdata;
                CFG_CAM_Z:      cam_z_reg      <= cfg_wdata;
                CFG_CAM_HEIGHT: cam_height_reg <= cfg_wdata;
                CFG_YAW:        yaw_reg        <= cfg_wdata;
                CFG_PITCH:      pitch_reg      <= cfg_wdata;
                CFG_BANK:       bank_reg       <= cfg_wdata;
                CFG_HORIZON:    horizon_reg    <= cfg_wdata;
                CFG_VIEW_MODE:  view_mode_reg  <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cfg.cam_x      = cam_x_reg;
        cfg.cam_z      = cam_z_reg;
        cfg.cam_height = cam_height_reg;
        cfg.yaw_s      = yaw_reg[31:16];
        cfg.yaw_c      = yaw_reg[15:0];
        cfg.pitch_s    = pitch_reg[31:16];
        cfg.pitch_c    = pitch_reg[15:0];
        cfg.bank_s     = bank_reg[31:16];
        cfg.bank_c     = bank_reg[15:0];
        cfg.horizon    = horizon_reg;
        cfg.pilot      = view_mode_reg;
    end

    // pipeline enables: the output register gates everything, the sequencer
    // additionally gates the tile front end
    logic     en, en_front, front_valid, can_load, tok_valid;
    tile_t    front_tile;
    vtx_tok_t tok;
    meta_t    out_meta;
    logic signed [31:0] screen_x, screen_y;

    assign en_front = en && (!front_valid || can_load);
    assign s_tready = en_front;

    qncp_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en_front), .in_valid(s_tvalid),
        .tile_x(s_tdata[31:0]), .tile_z(s_tdata[63:32]),
        .cell_size(s_tdata[87:64]), .eye_offset(s_tdata[119:88]),
        .cfg(cfg), .out_valid(front_valid), .out_tile(front_tile)
    );

    qncp_seq #(.NEAR_PLANE(NEAR_PLANE)) u_seq (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(front_valid), .tile(front_tile),
        .can_load(can_load), .tok_valid(tok_valid), .tok(tok)
    );

    qncp_vertex #(.NEAR_PLANE(NEAR_PLANE), .FOCAL_LENGTH(FOCAL_LENGTH)) u_vertex (
        .clk(clk), .rst_n(rst_n), .tok_valid(tok_valid), .tok(tok), .cfg(cfg),
        .en(en), .out_ready(m_tready), .out_valid(m_tvalid),
        .screen_x(screen_x), .screen_y(screen_y), .out_meta(out_meta)
    );

    assign m_tdata = {2'b00, out_meta.cnt, out_meta.idx, screen_y, screen_x};
    assign m_tuser = out_meta.vis;
    assign m_tlast = out_meta.last;

    // a culled tile is always a single word
    a_culled_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[69:64] == 6'd0)
        else $error("culled word without last or with nonzero index/count");

    // visible words carry a legal count and an index inside it
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[69:67] >= 3'd3 && m_tdata[69:67] <= 3'd6
                               && m_tdata[66:64] < m_tdata[69:67])
        else $error("vertex count or index out of range");

    // last marks exactly the final vertex of a visible polygon
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast == (m_tdata[66:64] == m_tdata[69:67] - 3'd1))
        else $error("last flag on the wrong vertex");

    // no tile is taken while the output is stalled
    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid || m_tready)
        else $error("input accepted during output stall");

endmodule

// ===== hdl/qncp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with tag pass-through.
`timescale 1ns / 1ps
module qncp_div #(
    parameter int NUM_W = 55,
    parameter int DEN_W = 39,
    parameter int Q_W   = 17,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [Q_W-1:0]   quot,
    output logic             ovf,
    output logic [TAG_W-1:0] tag_out
);

    localparam int IW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [IW-1:0]    rem_reg   [0:Q_W-1];
    logic [DEN_W-1:0] den_reg   [0:Q_W-1];
    logic [Q_W-1:0]   q_reg     [0:Q_W];
    logic             ovf_reg   [0:Q_W];
    logic [TAG_W-1:0] tag_reg   [0:Q_W];
    logic             valid_reg [0:Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= IW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= IW'(num) >= (IW'(den) << Q_W);
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [IW-1:0] sub;
        logic          take;

        always_comb
        begin
            sub  = IW'(den_reg[k]) << B;
            take = rem_reg[k] >= sub;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]   <= q_reg[k] | (Q_W'(take) << B);
                ovf_reg[k+1] <= ovf_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        if (k < Q_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? rem_reg[k] - sub : rem_reg[k];
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign quot      = q_reg[Q_W];
    assign ovf       = ovf_reg[Q_W];
    assign tag_out   = tag_reg[Q_W];

endmodule

// ===== hdl/qncp_front.sv =====
// Tile front end: pad the square and rotate its corners into camera space.
`timescale 1ns / 1ps
module qncp_front import qncp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] tile_x,
    input  logic signed [31:0] tile_z,
    input  logic        [23:0] cell_size,
    input  logic signed [31:0] eye_offset,
    input  cfg_t               cfg,
    output logic               out_valid,
    output tile_t              out_tile
);

    localparam logic signed [DX_W-1:0] PAD = DX_W'(PAD_Q16);

    logic                   f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic signed [DX_W-1:0] dxa_reg, dxb_reg, dza_reg, dzb_reg;
    logic signed [DX_W-1:0] dxa_next, dxb_next, dza_next, dzb_next;
    logic signed [31:0]     eye1_reg, eye2_reg;
    logic signed [PR_W-1:0] xac_reg, xbc_reg, xas_reg, xbs_reg;
    logic signed [PR_W-1:0] zac_reg, zbc_reg, zas_reg, zbs_reg;
    tile_t                  tile_reg, tile_next;

    always_comb
    begin
        dxa_next = DX_W'(tile_x) - PAD - DX_W'(cfg.cam_x);
        dxb_next = DX_W'(tile_x) + $signed(DX_W'(cell_size)) + PAD - DX_W'(cfg.cam_x);
        dza_next = DX_W'(tile_z) - PAD - DX_W'(cfg.cam_z);
        dzb_next = DX_W'(tile_z) + $signed(DX_W'(cell_size)) + PAD - DX_W'(cfg.cam_z);
    end

    // corner order: (a,a) (b,a) (b,b) (a,b) in (x,z)
    always_comb
    begin
        logic signed [PR_W:0]   dsx;
        logic signed [PR_W:0]   dsz;
        logic signed [PR_W-1:0] xc, xs, zc, zs;
        for (int i = 0; i < 4; i++)
        begin
            xc = (i == 1 || i == 2) ? xbc_reg : xac_reg;
            xs = (i == 1 || i == 2) ? xbs_reg : xas_reg;
            zc = (i >= 2) ? zbc_reg : zac_reg;
            zs = (i >= 2) ? zbs_reg : zas_reg;
            dsx = (PR_W+1)'(xc) - (PR_W+1)'(zs);
            dsz = (PR_W+1)'(xs) + (PR_W+1)'(zc);
            tile_next.lx[i] = LXZ_W'(dsx >>> 14) + LXZ_W'(eye2_reg);
            tile_next.lz[i] = LXZ_W'(dsz >>> 14);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxa_reg  <= dxa_next;
            dxb_reg  <= dxb_next;
            dza_reg  <= dza_next;
            dzb_reg  <= dzb_next;
            eye1_reg <= eye_offset;
            xac_reg  <= dxa_reg * cfg.yaw_c;
            xbc_reg  <= dxb_reg * cfg.yaw_c;
            xas_reg  <= dxa_reg * cfg.yaw_s;
            xbs_reg  <= dxb_reg * cfg.yaw_s;
            zac_reg  <= dza_reg * cfg.yaw_c;
            zbc_reg  <= dzb_reg * cfg.yaw_c;
            zas_reg  <= dza_reg * cfg.yaw_s;
            zbs_reg  <= dzb_reg * cfg.yaw_s;
            eye2_reg <= eye1_reg;
            tile_reg <= tile_next;
        end
    end

    assign out_valid = f3_valid_reg;
    assign out_tile  = tile_reg;

endmodule

// ===== hdl/qncp_seq.sv =====
// Clip sequencer: mark kept corners and crossing edges, emit one vertex word per cycle unless stalled.
`timescale 1ns / 1ps
module qncp_seq import qncp_pkg::*; #(
    parameter int NEAR_PLANE = NEAR_PLANE_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  tile_t    tile,
    output logic     can_load,
    output logic     tok_valid,
    output vtx_tok_t tok
);

    localparam logic signed [LXZ_W-1:0] NEAR_Q = LXZ_W'(NEAR_PLANE * 65536);

    logic       busy_reg, culled_reg, tok_valid_reg;
    tile_t      tile_reg;
    logic [7:0] mask_reg, mask_next;
    logic [2:0] cnt_reg, cnt_next, idx_reg;
    logic [3:0] n_raw;
    logic [3:0] in_f;
    logic [2:0] pick;
    logic [1:0] ci, cj;
    logic       last_now, load;
    vtx_tok_t   tok_reg, tok_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            in_f[i] = $signed(tile.lz[i]) >= NEAR_Q;
        for (int i = 0; i < 4; i++)
        begin
            mask_next[2*i]   = in_f[i];
            mask_next[2*i+1] = in_f[i] ^ in_f[(i + 1) % 4];
        end
        n_raw = '0;
        for (int k = 0; k < 8; k++)
            n_raw = n_raw + 4'(mask_next[k]);
        cnt_next = (n_raw > 4'd6) ? 3'd6 : n_raw[2:0];
    end

    always_comb
    begin
        pick = '0;
        for (int k = 7; k >= 0; k--)
            if (mask_reg[k])
                pick = 3'(k);
        ci = pick[2:1];
        cj = ci + 2'd1;
        last_now = busy_reg && (culled_reg || idx_reg == cnt_reg - 3'd1);
        can_load = !busy_reg || last_now;
        load     = en && in_valid && can_load;

        tok_next.lx_i  = $signed(tile_reg.lx[ci]);
        tok_next.lz_i  = $signed(tile_reg.lz[ci]);
        tok_next.lx_j  = $signed(tile_reg.lx[cj]);
        tok_next.lz_j  = $signed(tile_reg.lz[cj]);
        tok_next.crossing = pick[0];
        tok_next.meta.idx  = culled_reg ? 3'd0 : idx_reg;
        tok_next.meta.cnt  = culled_reg ? 3'd0 : cnt_reg;
        tok_next.meta.vis  = !culled_reg;
        tok_next.meta.last = last_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tok_valid_reg <= busy_reg;
            if (load)
                busy_reg <= 1'b1;
            else if (last_now)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tile_reg   <= tile;
            mask_reg   <= mask_next;
            cnt_reg    <= cnt_next;
            culled_reg <= n_raw < 4'd3;
            idx_reg    <= '0;
        end
        else if (en && busy_reg)
        begin
            mask_reg <= mask_reg & ~(8'b1 << pick);
            idx_reg  <= idx_reg + 3'd1;
        end
        if (en)
            tok_reg <= tok_next;
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

// ===== hdl/qncp_vertex.sv =====
// Vertex pipeline: edge lerp, pitch, perspective divide, bank and output register.
`timescale 1ns / 1ps
module qncp_vertex import qncp_pkg::*; #(
    parameter int NEAR_PLANE   = NEAR_PLANE_DEF,
    parameter int FOCAL_LENGTH = FOCAL_LENGTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  vtx_tok_t           tok,
    input  cfg_t               cfg,
    output logic               en,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output meta_t              out_meta
);

    localparam int FOC_W  = $clog2(FOCAL_LENGTH + 1);
    localparam int NUMP_W = LY_W + FOC_W + 16;
    localparam int NUMT_W = DL_W + 16;
    localparam int PT_W   = T_W + 1 + DL_W;
    localparam int PZ_W   = OX_W + 16;
    localparam int PB_W   = 33 + 16;
    localparam int TT_W   = $bits(tdiv_tag_t);
    localparam int TX_W   = $bits(meta_t) + 1;
    localparam logic signed [LXZ_W-1:0] NEAR_Q  = LXZ_W'(NEAR_PLANE * 65536);
    localparam logic signed [LY_W-1:0]  NEAR_L  = LY_W'(NEAR_PLANE * 65536);
    localparam logic        [T_W-1:0]   T_ONE   = T_W'(65536);
    localparam logic signed [47:0]      CENTRE  = 48'(CENTRE_X_Q16);
    localparam logic signed [32:0]      CENTRE33 = 33'(CENTRE_X_Q16);

    // stage 1: crossing-edge divide operands
    logic signed [DL_W-1:0] dn, dd;
    logic [NUMT_W-1:0]      tnum;
    logic [DL_W-1:0]        tden;
    tdiv_tag_t              ttag_in, ttag_out;
    logic [TT_W-1:0]        ttag_out_bits;
    logic                   tq_valid, tq_ovf;
    logic [T_W-1:0]         tq;

    always_comb
    begin
        dn   = DL_W'(NEAR_Q) - DL_W'(tok.lz_i);
        dd   = DL_W'(tok.lz_j) - DL_W'(tok.lz_i);
        tnum = NUMT_W'(dn[DL_W-1] ? -dn : dn) << 16;
        tden = dd[DL_W-1] ? -dd : dd;
        ttag_in.lx_i     = tok.lx_i;
        ttag_in.dlx      = DL_W'(tok.lx_j) - DL_W'(tok.lx_i);
        ttag_in.lz_i     = tok.lz_i;
        ttag_in.crossing = tok.crossing;
        ttag_in.pos      = dn[DL_W-1] == dd[DL_W-1];
        ttag_in.den_zero = dd == '0;
        ttag_in.meta     = tok.meta;
    end

    qncp_div #(.NUM_W(NUMT_W), .DEN_W(DL_W), .Q_W(T_W), .TAG_W(TT_W)) u_tdiv (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(tok_valid), .num(tnum), .den(tden), .tag_in(ttag_in),
        .out_valid(tq_valid), .quot(tq), .ovf(tq_ovf), .tag_out(ttag_out_bits)
    );
    assign ttag_out = tdiv_tag_t'(ttag_out_bits);

    // stages 2..7
    logic                    v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [T_W-1:0]          t2_reg;
    tdiv_tag_t               g2_reg, g3_reg;
    logic signed [PT_W-1:0]  prod3_reg;
    logic signed [OX_W-1:0]  ox4_reg, ox5_reg, ox6_reg;
    logic signed [OX_W-1:0]  ox_next;
    logic signed [OX_W-1:0]  oz4_reg, oz5_reg;
    meta_t                   m4_reg, m5_reg, m6_reg, m7_reg;
    logic signed [PZ_W-1:0]  pyc_reg, pzs_reg, pys_reg, pzc_reg;
    logic signed [LY_W-1:0]  ly6_reg, lz6_reg, ly_next, lz_next;
    logic [NUMP_W-1:0]       nx7_reg, ny7_reg;
    logic                    sxn7_reg, syn7_reg;
    logic [LY_W-1:0]         den7_reg;
    logic [OX_W-1:0]         ax;
    logic [LY_W-1:0]         ay;

    always_comb
    begin
        logic signed [PZ_W:0] s_y, s_z;
        ox_next = OX_W'(g3_reg.lx_i) + OX_W'(prod3_reg >>> 16);
        s_y = (PZ_W+1)'(pyc_reg) - (PZ_W+1)'(pzs_reg);
        s_z = (PZ_W+1)'(pys_reg) + (PZ_W+1)'(pzc_reg);
        if (cfg.pilot)
        begin
            ly_next = LY_W'(s_y >>> 14);
            lz_next = LY_W'(s_z >>> 14);
        end
        else
        begin
            ly_next = LY_W'(cfg.cam_height);
            lz_next = LY_W'(oz5_reg);
        end
        if (lz_next < NEAR_L)
            lz_next = NEAR_L;
        ax = ox6_reg[OX_W-1] ? OX_W'(-ox6_reg) : OX_W'(ox6_reg);
        ay = ly6_reg[LY_W-1] ? LY_W'(-ly6_reg) : LY_W'(ly6_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= tq_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // clamp t to 0..1, zero for an empty or opposite-sign ratio
            if (!ttag_out.pos || ttag_out.den_zero)
                t2_reg <= '0;
            else if (tq_ovf || tq > T_ONE)
                t2_reg <= T_ONE;
            else
                t2_reg <= tq;
            g2_reg    <= ttag_out;
            prod3_reg <= $signed({1'b0, t2_reg}) * g2_reg.dlx;
            g3_reg    <= g2_reg;
            ox4_reg   <= g3_reg.crossing ? ox_next : OX_W'(g3_reg.lx_i);
            oz4_reg   <= g3_reg.crossing ? OX_W'(NEAR_Q) : OX_W'(g3_reg.lz_i);
            m4_reg    <= g3_reg.meta;
            pyc_reg   <= cfg.cam_height * cfg.pitch_c;
            pzs_reg   <= oz4_reg * cfg.pitch_s;
            pys_reg   <= cfg.cam_height * cfg.pitch_s;
            pzc_reg   <= oz4_reg * cfg.pitch_c;
            ox5_reg   <= ox4_reg;
            oz5_reg   <= oz4_reg;
            m5_reg    <= m4_reg;
            ox6_reg   <= ox5_reg;
            ly6_reg   <= ly_next;
            lz6_reg   <= lz_next;
            m6_reg    <= m5_reg;
            nx7_reg   <= (NUMP_W'(ax) * NUMP_W'(FOCAL_LENGTH)) << 16;
            ny7_reg   <= (NUMP_W'(ay) * NUMP_W'(FOCAL_LENGTH)) << 16;
            sxn7_reg  <= ox6_reg[OX_W-1];
            syn7_reg  <= ly6_reg[LY_W-1];
            den7_reg  <= LY_W'(lz6_reg);
            m7_reg    <= m6_reg;
        end
    end

    // perspective divides, shared depth
    logic              qx_valid, qx_ovf, qy_valid, qy_ovf;
    logic [QP_W-1:0]   qx, qy;
    logic [TX_W-1:0]   xtag_out;
    logic              ytag_out;
    meta_t             mq;
    logic              sxn_q;

    qncp_div #(.NUM_W(NUMP_W), .DEN_W(LY_W), .Q_W(QP_W), .TAG_W(TX_W)) u_xdiv (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v7_reg), .num(nx7_reg), .den(den7_reg), .tag_in({sxn7_reg, m7_reg}),
        .out_valid(qx_valid), .quot(qx), .ovf(qx_ovf), .tag_out(xtag_out)
    );

    qncp_div #(.NUM_W(NUMP_W), .DEN_W(LY_W), .Q_W(QP_W), .TAG_W(1)) u_ydiv (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v7_reg), .num(ny7_reg), .den(den7_reg), .tag_in(syn7_reg),
        .out_valid(qy_valid), .quot(qy), .ovf(qy_ovf), .tag_out(ytag_out)
    );

    assign sxn_q = xtag_out[TX_W-1];
    assign mq    = meta_t'(xtag_out[TX_W-2:0]);

    // stages 8..10
    logic               v8_reg, v9_reg, out_valid_reg;
    logic signed [31:0] sx8_reg, sy8_reg, sx8_next, sy8_next;
    logic signed [31:0] sx9_reg, sy9_reg;
    meta_t              m8_reg, m9_reg, m_out_reg;
    logic               bank9_reg;
    logic signed [PB_W-1:0] dxc_reg, dys_reg, dxs_reg, dyc_reg;
    logic signed [32:0]     dx8, dy8;
    logic signed [31:0]     sx_out_reg, sy_out_reg, sx10_next, sy10_next;

    always_comb
    begin
        logic signed [QP_W+1:0] sq_x, sq_y;
        sq_x = $signed({2'b00, qx});
        sq_y = $signed({2'b00, qy});
        if (sxn_q)
            sq_x = -sq_x;
        if (ytag_out)
            sq_y = -sq_y;
        if (qx_ovf)
            sx8_next = sxn_q ? 32'sh80000000 : 32'sh7fffffff;
        else
            sx8_next = sat32(CENTRE + 48'(sq_x));
        if (qy_ovf)
            sy8_next = ytag_out ? 32'sh80000000 : 32'sh7fffffff;
        else
            sy8_next = sat32(48'(cfg.horizon) + 48'(sq_y));
        dx8 = 33'(sx8_reg) - CENTRE33;
        dy8 = 33'(sy8_reg) - 33'(cfg.horizon);
    end

    always_comb
    begin
        logic signed [PB_W:0] rx, ry;
        rx = (PB_W+1)'(dxc_reg) - (PB_W+1)'(dys_reg);
        ry = (PB_W+1)'(dxs_reg) + (PB_W+1)'(dyc_reg);
        if (bank9_reg)
        begin
            sx10_next = sat32(CENTRE + 48'(rx >>> 14));
            sy10_next = sat32(48'(cfg.horizon) + 48'(ry >>> 14));
        end
        else
        begin
            sx10_next = sx9_reg;
            sy10_next = sy9_reg;
        end
        if (!m9_reg.vis)
        begin
            sx10_next = '0;
            sy10_next = '0;
        end
    end

    assign en = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v8_reg        <= qx_valid & qy_valid;
            v9_reg        <= v8_reg;
            out_valid_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx8_reg    <= sx8_next;
            sy8_reg    <= sy8_next;
            m8_reg     <= mq;
            dxc_reg    <= dx8 * cfg.bank_c;
            dys_reg    <= dy8 * cfg.bank_s;
            dxs_reg    <= dx8 * cfg.bank_s;
            dyc_reg    <= dy8 * cfg.bank_c;
            sx9_reg    <= sx8_reg;
            sy9_reg    <= sy8_reg;
            m9_reg     <= m8_reg;
            bank9_reg  <= cfg.pilot && (cfg.bank_s >= 16'(BANK_MIN) || cfg.bank_s <= -16'(BANK_MIN));
            sx_out_reg <= sx10_next;
            sy_out_reg <= sy10_next;
            m_out_reg  <= m9_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = sx_out_reg;
    assign screen_y  = sy_out_reg;
    assign out_meta  = m_out_reg;

endmodule
